>>> rtl/lcp_pkg.sv
// Shared constants, status codes and scan flag type of the pinned-entry LRU cache.
// Used by lcp_scan and lru_cache_with_pinned_entries_top; no dependencies.
package lcp_pkg;

    // Default geometry of the cache
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_TIME_BITS = 32;

    // Fixed field widths
    localparam int LIMIT_BITS    = 5;
    localparam int USER_BITS     = 8;
    localparam int STATUS_BITS   = 3;
    localparam int SLOT_OUT_BITS = 4;
    localparam int EVK_OUT_BITS  = 32;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
    localparam logic [USER_BITS-1:0]  USER_MAX    = 8'hFF;
    localparam logic [USER_BITS-1:0]  USER_ONE    = 8'h01;

    // Commands
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef logic [STATUS_BITS-1:0] t_status;

    // Result status codes
    localparam t_status ST_HIT       = 3'd0;
    localparam t_status ST_INSERTED  = 3'd1;
    localparam t_status ST_INS_EVICT = 3'd2;
    localparam t_status ST_LOAD_FAIL = 3'd3;
    localparam t_status ST_PINNED    = 3'd4;
    localparam t_status ST_RELEASED  = 3'd5;
    localparam t_status ST_REL_MISS  = 3'd6;

    // Outcome of one pass over the entry memory
    typedef struct packed {
        logic done;    // pass finished, fields below are stable
        logic hit;     // a valid entry holds the key
        logic victim;  // a valid entry with no users exists
        logic free;    // an invalid slot exists
    } t_scan_flags;

endpackage

>>> rtl/lru_cache_with_pinned_entries_top.sv
// Top level of the pinned-entry LRU cache: valid bits, fill count, control FSM.
// Depends on lcp_pkg, lcp_entry_ram and lcp_scan.
//
// A transaction is taken when start is high and busy is low; each one returns exactly
// one result, shown for a single cycle with o_valid, which the receiver must take.
// Every transaction makes one pass over the entry memory, one slot per cycle through
// its single read port, and the block stays busy until its result is given. A missed
// request that must evict more than once, after cache_limit was lowered, makes one
// more pass per extra eviction. Valid bits are flip-flops cleared by reset, so no
// clearing pass is needed.
// cache_limit may be written any time the block is idle; 0 acts as 1, values above
// ENTRIES act as ENTRIES.
module lru_cache_with_pinned_entries_top #(
    parameter int ENTRIES   = lcp_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = lcp_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS = lcp_pkg::DEF_TIME_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic [KEY_BITS-1:0]              i_key,
    input  logic [TIME_BITS-1:0]             i_now,
    input  logic                             i_load_ok,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lcp_pkg::LIMIT_BITS-1:0]   i_cfg_data,
    output logic                             o_valid,
    output lcp_pkg::t_status                 o_status,
    output logic [lcp_pkg::SLOT_OUT_BITS-1:0] o_slot,
    output logic [lcp_pkg::EVK_OUT_BITS-1:0] o_evicted_key
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lcp_pkg::LIMIT_BITS) ? CNT_W : lcp_pkg::LIMIT_BITS;
    localparam int WORD_W = KEY_BITS + TIME_BITS + lcp_pkg::USER_BITS;
    localparam int SLOT_W = lcp_pkg::SLOT_OUT_BITS;
    localparam int EVK_W  = lcp_pkg::EVK_OUT_BITS;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                          r_state;
    logic [ENTRIES-1:0]            r_valid;
    logic [CNT_W-1:0]              r_count;
    logic [lcp_pkg::LIMIT_BITS-1:0] r_limit;
    logic                          r_cmd;
    logic [KEY_BITS-1:0]           r_key;
    logic [TIME_BITS-1:0]          r_now;
    logic                          r_load_ok;
    logic                          r_evicted;
    logic [KEY_BITS-1:0]           r_evk;
    logic                          r_out_valid;
    lcp_pkg::t_status              r_out_status;
    logic [SLOT_W-1:0]             r_out_slot;
    logic [EVK_W-1:0]              r_out_evk;

    logic                          accept;
    logic                          scan_start;
    logic                          scan_end;
    lcp_pkg::t_scan_flags          flags;
    logic [IDX_W-1:0]              raddr;
    logic [WORD_W-1:0]             rdata;
    logic [IDX_W-1:0]              hit_idx;
    logic [TIME_BITS-1:0]          hit_time;
    logic [lcp_pkg::USER_BITS-1:0] hit_users;
    logic [IDX_W-1:0]              vic_idx;
    logic [KEY_BITS-1:0]           vic_key;
    logic [IDX_W-1:0]              free_idx;

    logic [CMP_W-1:0]              cnt_ext;
    logic [CMP_W-1:0]              lim_ext;
    logic [CMP_W-1:0]              eff_lim;
    logic                          at_limit;
    logic                          still_full;

    logic                          finish;
    logic                          rescan;
    logic                          evict;
    logic                          insert;
    logic                          we;
    logic [IDX_W-1:0]              waddr;
    logic [WORD_W-1:0]             wdata;
    logic [IDX_W-1:0]              ins_idx;
    lcp_pkg::t_status              res_status;
    logic [IDX_W-1:0]              res_idx;
    logic [KEY_BITS-1:0]           res_evk;
    logic [SLOT_W+IDX_W-1:0]       slot_wide;
    logic [EVK_W+KEY_BITS-1:0]     evk_wide;
    logic [CNT_W-1:0]              n_count;
    logic [ENTRIES-1:0]            n_valid;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign scan_start  = accept || rescan;
    assign scan_end    = (r_state == S_SCAN) && flags.done;

    lcp_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lcp_scan #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (scan_start),
        .i_key       (r_key),
        .i_valid     (r_valid),
        .i_rdata     (rdata),
        .o_raddr     (raddr),
        .o_flags     (flags),
        .o_hit_idx   (hit_idx),
        .o_hit_time  (hit_time),
        .o_hit_users (hit_users),
        .o_vic_idx   (vic_idx),
        .o_vic_key   (vic_key),
        .o_free_idx  (free_idx)
    );

    // Clamp the limit into 1..ENTRIES and compare against the fill count
    always_comb begin
        cnt_ext = CMP_W'(r_count);
        lim_ext = CMP_W'(r_limit);
        if (lim_ext == '0) begin
            eff_lim = CMP_W'(1);
        end else if (lim_ext > CMP_W'(ENTRIES)) begin
            eff_lim = CMP_W'(ENTRIES);
        end else begin
            eff_lim = lim_ext;
        end
        at_limit   = (cnt_ext >= eff_lim);
        still_full = ((cnt_ext - 1'b1) >= eff_lim);
    end

    // Insert into the lowest free slot, counting a slot freed in this same cycle
    assign ins_idx = (flags.free && (free_idx < vic_idx)) ? free_idx : vic_idx;

    // Decide the outcome at the end of a pass
    always_comb begin
        finish     = 1'b0;
        rescan     = 1'b0;
        evict      = 1'b0;
        insert     = 1'b0;
        we         = 1'b0;
        waddr      = hit_idx;
        wdata      = {r_key, r_now, lcp_pkg::USER_ONE};
        res_status = lcp_pkg::ST_LOAD_FAIL;
        res_idx    = '0;
        res_evk    = '0;
        if (scan_end) begin
            if (r_cmd == lcp_pkg::CMD_RELEASE) begin
                finish = 1'b1;
                if (flags.hit) begin
                    we    = 1'b1;
                    wdata = {r_key, hit_time,
                             (hit_users == '0) ? hit_users : hit_users - 1'b1};
                    res_status = lcp_pkg::ST_RELEASED;
                    res_idx    = hit_idx;
                end else begin
                    res_status = lcp_pkg::ST_REL_MISS;
                end
            end else if (flags.hit) begin
                finish = 1'b1;
                we     = 1'b1;
                wdata  = {r_key, r_now,
                          (hit_users == lcp_pkg::USER_MAX) ? hit_users : hit_users + 1'b1};
                res_status = lcp_pkg::ST_HIT;
                res_idx    = hit_idx;
            end else if (!r_load_ok) begin
                finish     = 1'b1;
                res_status = lcp_pkg::ST_LOAD_FAIL;
            end else if (at_limit) begin
                if (flags.victim) begin
                    evict = 1'b1;
                    if (still_full) begin
                        rescan = 1'b1;
                    end else begin
                        finish     = 1'b1;
                        insert     = 1'b1;
                        we         = 1'b1;
                        waddr      = ins_idx;
                        res_status = lcp_pkg::ST_INS_EVICT;
                        res_idx    = ins_idx;
                        res_evk    = r_evicted ? r_evk : vic_key;
                    end
                end else begin
                    finish     = 1'b1;
                    res_status = lcp_pkg::ST_PINNED;
                end
            end else begin
                finish     = 1'b1;
                insert     = 1'b1;
                we         = 1'b1;
                waddr      = free_idx;
                res_idx    = free_idx;
                res_status = r_evicted ? lcp_pkg::ST_INS_EVICT : lcp_pkg::ST_INSERTED;
                res_evk    = r_evicted ? r_evk : '0;
            end
        end
    end

    // Fit the slot index and key to the result field widths
    assign slot_wide = {{SLOT_W{1'b0}}, res_idx};
    assign evk_wide  = {{EVK_W{1'b0}}, res_evk};
    assign n_count   = r_count - CNT_W'(evict) + CNT_W'(insert);

    // Drop the evicted slot, then mark the inserted one
    always_comb begin
        n_valid = r_valid;
        if (evict) begin
            n_valid[vic_idx] = 1'b0;
        end
        if (insert) begin
            n_valid[waddr] = 1'b1;
        end
    end

    // Control state: FSM, valid bits, fill count, limit register, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_limit     <= lcp_pkg::LIMIT_RESET;
            r_evicted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= finish;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state   <= S_SCAN;
                        r_evicted <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                    if (evict) begin
                        r_evicted <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Hold the transaction fields, the first evicted key and the result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_key     <= i_key;
            r_now     <= i_now;
            r_load_ok <= i_load_ok;
        end
        if (evict && !r_evicted) begin
            r_evk <= vic_key;
        end
        if (finish) begin
            r_out_status <= res_status;
            r_out_slot   <= slot_wide[SLOT_W-1:0];
            r_out_evk    <= evk_wide[EVK_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_evicted_key = r_out_evk;

    // Fill count tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("fill count differs from number of valid entries");

    // A result only closes a transaction that was in progress
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // An accepted transaction occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("block not busy after accepting a transaction");

    // Pinned outcome reports no slot and no evicted key
    a_pinned_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == lcp_pkg::ST_PINNED)) |-> (o_slot == '0 && o_evicted_key == '0))
        else $error("all-pinned result carries slot or evicted key");

    // An insertion never targets a slot that stays valid
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (insert && !evict) |-> !r_valid[waddr])
        else $error("insertion into an occupied slot");

endmodule

>>> rtl/lcp_entry_ram.sv
// Entry memory: one write port, one read port, registered read data.
// Generic; no package dependencies.
module lcp_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 72,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read through an output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lcp_scan.sv
// Scan engine: walks the entry memory once per pass, one slot a cycle, and finds
// the matching key, the oldest unpinned entry and the lowest free slot. Uses lcp_pkg.
module lcp_scan #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 32,
    parameter int TIME_BITS = 32,
    localparam int IDX_W  = $clog2(ENTRIES),
    localparam int WORD_W = KEY_BITS + TIME_BITS + lcp_pkg::USER_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [ENTRIES-1:0]              i_valid,
    input  logic [WORD_W-1:0]               i_rdata,
    output logic [IDX_W-1:0]                o_raddr,
    output lcp_pkg::t_scan_flags            o_flags,
    output logic [IDX_W-1:0]                o_hit_idx,
    output logic [TIME_BITS-1:0]            o_hit_time,
    output logic [lcp_pkg::USER_BITS-1:0]   o_hit_users,
    output logic [IDX_W-1:0]                o_vic_idx,
    output logic [KEY_BITS-1:0]             o_vic_key,
    output logic [IDX_W-1:0]                o_free_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic                          r_active;
    logic [IDX_W-1:0]              r_addr;
    logic                          r_cmp_vld;
    logic [IDX_W-1:0]              r_cmp_idx;
    logic                          r_done;
    logic                          r_hit;
    logic                          r_vic;
    logic                          r_free;
    logic [IDX_W-1:0]              r_hit_idx;
    logic [TIME_BITS-1:0]          r_hit_time;
    logic [lcp_pkg::USER_BITS-1:0] r_hit_users;
    logic [IDX_W-1:0]              r_vic_idx;
    logic [KEY_BITS-1:0]           r_vic_key;
    logic [TIME_BITS-1:0]          r_vic_time;
    logic [IDX_W-1:0]              r_free_idx;

    logic [KEY_BITS-1:0]           rd_key;
    logic [TIME_BITS-1:0]          rd_time;
    logic [lcp_pkg::USER_BITS-1:0] rd_users;
    logic                          cmp_valid;
    logic                          is_match;
    logic                          is_cand;
    logic                          is_free;

    // Unpack the entry word that arrives for the slot under compare
    assign rd_key    = i_rdata[WORD_W-1 -: KEY_BITS];
    assign rd_time   = i_rdata[lcp_pkg::USER_BITS +: TIME_BITS];
    assign rd_users  = i_rdata[lcp_pkg::USER_BITS-1:0];
    assign cmp_valid = i_valid[r_cmp_idx];

    // Lowest match, oldest unpinned (strict less keeps the lowest slot), lowest free
    assign is_match = r_cmp_vld && cmp_valid && !r_hit && (rd_key == i_key);
    assign is_cand  = r_cmp_vld && cmp_valid && (rd_users == '0) &&
                      (!r_vic || (rd_time < r_vic_time));
    assign is_free  = r_cmp_vld && !cmp_valid && !r_free;

    assign o_raddr = r_addr;

    // Sequence the address counter and the found flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_vic     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_cmp_vld <= r_active;
            r_done    <= r_cmp_vld && (r_cmp_idx == LAST_IDX);
            if (i_start) begin
                r_active <= 1'b1;
                r_addr   <= '0;
                r_hit    <= 1'b0;
                r_vic    <= 1'b0;
                r_free   <= 1'b0;
            end else begin
                if (r_active) begin
                    if (r_addr == LAST_IDX) begin
                        r_active <= 1'b0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                if (is_match) r_hit  <= 1'b1;
                if (is_cand)  r_vic  <= 1'b1;
                if (is_free)  r_free <= 1'b1;
            end
        end
    end

    // Capture the payload of each candidate
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (is_match) begin
            r_hit_idx   <= r_cmp_idx;
            r_hit_time  <= rd_time;
            r_hit_users <= rd_users;
        end
        if (is_cand) begin
            r_vic_idx  <= r_cmp_idx;
            r_vic_key  <= rd_key;
            r_vic_time <= rd_time;
        end
        if (is_free) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    assign o_flags.done   = r_done;
    assign o_flags.hit    = r_hit;
    assign o_flags.victim = r_vic;
    assign o_flags.free   = r_free;
    assign o_hit_idx      = r_hit_idx;
    assign o_hit_time     = r_hit_time;
    assign o_hit_users    = r_hit_users;
    assign o_vic_idx      = r_vic_idx;
    assign o_vic_key      = r_vic_key;
    assign o_free_idx     = r_free_idx;

endmodule

>>> sim/lru_cache_with_pinned_entries_top_test.sv
// Self-checking testbench for the pinned-entry LRU cache: directed table, user-count walk, then random traffic.
// Holds its own cache shadow to predict every result; depends on lcp_pkg and the top level.
module lru_cache_with_pinned_entries_top_test;

    localparam int ENTRIES     = lcp_pkg::DEF_ENTRIES;
    localparam int KEY_W       = lcp_pkg::DEF_KEY_BITS;
    localparam int TIME_W      = lcp_pkg::DEF_TIME_BITS;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 85;
    localparam int DIR_ROWS    = 27;

    typedef struct packed {
        lcp_pkg::t_status                   status;
        logic [lcp_pkg::SLOT_OUT_BITS-1:0]  slot;
        logic [lcp_pkg::EVK_OUT_BITS-1:0]   evicted_key;
    } t_cache_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic                               cmd;
        logic [KEY_W-1:0]                   key;
        logic [TIME_W-1:0]                  now;
        logic                               load_ok;
        logic [lcp_pkg::LIMIT_BITS-1:0]     limit;
        logic                               typed;
        lcp_pkg::t_status                   status;
        logic [lcp_pkg::SLOT_OUT_BITS-1:0]  slot;
        logic [lcp_pkg::EVK_OUT_BITS-1:0]   evicted_key;
    } t_dir_row;

    // Directed stimulus; expected fields count only where typed is set
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_INSERTED, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_INSERTED, 4'd1, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'h0000_0000, 32'd5, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'h1234_5678, 32'd6, 1'b0, 5'd0, 1'b1,
          lcp_pkg::ST_LOAD_FAIL, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'h0000_0000, 32'd0, 1'b0, 5'd0, 1'b1,
          lcp_pkg::ST_RELEASED, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'h0000_0000, 32'd0, 1'b0, 5'd0, 1'b1,
          lcp_pkg::ST_RELEASED, 4'd0, 32'h0},
        // release with no users left keeps the count at zero
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'h0000_0000, 32'd0, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_RELEASED, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'hAAAA_5555, 32'd0, 1'b0, 5'd0, 1'b1,
          lcp_pkg::ST_REL_MISS, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'hFFFF_FFFF, 32'd0, 1'b0, 5'd0, 1'b1,
          lcp_pkg::ST_RELEASED, 4'd1, 32'h0},
        '{ROW_CFG, lcp_pkg::CMD_REQUEST, 32'h0, 32'h0, 1'b0, 5'd2, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd5, 32'd7, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_INS_EVICT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd6, 32'hFFFF_FFFF, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_INS_EVICT, 4'd1, 32'hFFFF_FFFF},
        // every entry has users: nothing can be evicted
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd7, 32'd8, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_PINNED, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd5, 32'd9, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd6, 32'd9, 1'b1, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'd5, 32'd0, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'd5, 32'd0, 1'b1, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'd6, 32'd0, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'd6, 32'd0, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        // equal stamps on both free entries: lowest slot goes
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd8, 32'd10, 1'b1, 5'd0, 1'b1,
          lcp_pkg::ST_INS_EVICT, 4'd0, 32'd5},
        '{ROW_CFG, lcp_pkg::CMD_REQUEST, 32'h0, 32'h0, 1'b0, 5'd31, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd9, 32'd11, 1'b1, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'd9, 32'd0, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_CFG, lcp_pkg::CMD_REQUEST, 32'h0, 32'h0, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        // limit lowered: several evictions, then stuck on a pinned entry
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd11, 32'd12, 1'b1, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_RELEASE, 32'd8, 32'd0, 1'b0, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0},
        '{ROW_ITEM, lcp_pkg::CMD_REQUEST, 32'd11, 32'd13, 1'b1, 5'd0, 1'b0,
          lcp_pkg::ST_HIT, 4'd0, 32'h0}
    };

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic                               i_cmd;
    logic [KEY_W-1:0]                   i_key;
    logic [TIME_W-1:0]                  i_now;
    logic                               i_load_ok;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [lcp_pkg::LIMIT_BITS-1:0]     i_cfg_data;
    logic                               o_valid;
    lcp_pkg::t_status                   o_status;
    logic [lcp_pkg::SLOT_OUT_BITS-1:0]  o_slot;
    logic [lcp_pkg::EVK_OUT_BITS-1:0]   o_evicted_key;

    // Shadow of the cache contents and its limit register
    logic                               shadow_valid [ENTRIES];
    logic [KEY_W-1:0]                   shadow_key [ENTRIES];
    logic [TIME_W-1:0]                  shadow_last_use [ENTRIES];
    logic [lcp_pkg::USER_BITS-1:0]      shadow_users [ENTRIES];
    logic [lcp_pkg::LIMIT_BITS-1:0]     shadow_limit;

    t_cache_result                      expected_outcomes [$];
    logic [KEY_W-1:0]                   key_pool [POOL_SIZE];
    logic [TIME_W-1:0]                  now_stamp;
    int                                 idle_pct;
    int                                 error_count = 0;
    int                                 cycle_count = 0;

    lru_cache_with_pinned_entries_top #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_W),
        .TIME_BITS (TIME_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_now         (i_now),
        .i_load_ok     (i_load_ok),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_evicted_key (o_evicted_key)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void log_mismatch(input string text);
        error_count++;
        if (error_count <= 10)
            $display("%s", text);
    endfunction

    // Apply one transaction to the shadow cache and return its result
    task automatic apply_cache_access(input logic cmd, input logic [KEY_W-1:0] key,
                                      input logic [TIME_W-1:0] now, input logic load_ok,
                                      output t_cache_result res);
        int i;
        int hit_slot;
        int victim;
        int free_slot;
        int fill;
        int lim;
        bit evicted_any;
        bit stuck;
        res = '0;
        hit_slot = -1;
        for (i = ENTRIES - 1; i >= 0; i--)
            if (shadow_valid[i] && shadow_key[i] == key)
                hit_slot = i;
        if (cmd == lcp_pkg::CMD_RELEASE) begin
            if (hit_slot >= 0) begin
                if (shadow_users[hit_slot] != '0)
                    shadow_users[hit_slot]--;
                res.status = lcp_pkg::ST_RELEASED;
                res.slot = lcp_pkg::SLOT_OUT_BITS'(hit_slot);
            end else begin
                res.status = lcp_pkg::ST_REL_MISS;
            end
        end else if (hit_slot >= 0) begin
            shadow_last_use[hit_slot] = now;
            if (shadow_users[hit_slot] != lcp_pkg::USER_MAX)
                shadow_users[hit_slot]++;
            res.status = lcp_pkg::ST_HIT;
            res.slot = lcp_pkg::SLOT_OUT_BITS'(hit_slot);
        end else if (!load_ok) begin
            res.status = lcp_pkg::ST_LOAD_FAIL;
        end else begin
            lim = int'(shadow_limit);
            if (lim == 0)
                lim = 1;
            if (lim > ENTRIES)
                lim = ENTRIES;
            fill = 0;
            for (i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    fill++;
            evicted_any = 1'b0;
            stuck = 1'b0;
            // evict the oldest entry without users until below the limit
            while (fill >= lim && !stuck) begin
                victim = -1;
                for (i = 0; i < ENTRIES; i++)
                    if (shadow_valid[i] && shadow_users[i] == '0)
                        if (victim < 0 || shadow_last_use[i] < shadow_last_use[victim])
                            victim = i;
                if (victim < 0) begin
                    stuck = 1'b1;
                end else begin
                    if (!evicted_any)
                        res.evicted_key = lcp_pkg::EVK_OUT_BITS'(shadow_key[victim]);
                    evicted_any = 1'b1;
                    shadow_valid[victim] = 1'b0;
                    fill--;
                end
            end
            if (fill >= lim) begin
                res.status = lcp_pkg::ST_PINNED;
                res.evicted_key = '0;
            end else begin
                free_slot = -1;
                for (i = ENTRIES - 1; i >= 0; i--)
                    if (!shadow_valid[i])
                        free_slot = i;
                shadow_valid[free_slot] = 1'b1;
                shadow_key[free_slot] = key;
                shadow_last_use[free_slot] = now;
                shadow_users[free_slot] = lcp_pkg::USER_ONE;
                res.slot = lcp_pkg::SLOT_OUT_BITS'(free_slot);
                res.status = evicted_any ? lcp_pkg::ST_INS_EVICT : lcp_pkg::ST_INSERTED;
            end
        end
    endtask

    // Drive one transaction from a falling edge; return at the falling edge after acceptance
    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] now, input logic load_ok,
                             input bit typed, input t_cache_result typed_res);
        t_cache_result predicted;
        // idle the sender cycle by cycle
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_key     <= key;
        i_now     <= now;
        i_load_ok <= load_ok;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_cache_access(cmd, key, now, load_ok, predicted);
        expected_outcomes.insert(expected_outcomes.size(), typed ? typed_res : predicted);
        @(negedge i_clk);
    endtask

    // Write the limit register once every expected result has come back
    task automatic write_limit(input logic [lcp_pkg::LIMIT_BITS-1:0] value);
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        shadow_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly pool keys so hits, releases and evictions happen; some stray keys miss
    task automatic run_random_phase(input int count);
        logic [KEY_W-1:0] key;
        logic             cmd;
        logic             ok;
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(99) < 48) ? lcp_pkg::CMD_RELEASE : lcp_pkg::CMD_REQUEST;
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                            : KEY_W'($urandom);
            ok = ($urandom_range(99) < 85);
            if ($urandom_range(99) < 3)
                now_stamp = TIME_W'($urandom);
            else
                now_stamp = now_stamp + TIME_W'($urandom_range(0, 3));
            send_item(cmd, key, now_stamp, ok, 1'b0, '0);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                log_mismatch($sformatf("result with nothing expected: status %0d slot %0d key %h",
                                       o_status, o_slot, o_evicted_key));
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.status || o_slot !== want.slot ||
                    o_evicted_key !== want.evicted_key)
                    log_mismatch($sformatf(
                        "mismatch: expected status %0d slot %0d key %h, got %0d %0d %h",
                        want.status, want.slot, want.evicted_key,
                        o_status, o_slot, o_evicted_key));
            end
        end
    end

    initial begin
        t_dir_row      row;
        t_cache_result typed_res;
        logic [lcp_pkg::LIMIT_BITS-1:0] phase_limit [PHASES];
        int            phase_idle [PHASES];
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = lcp_pkg::CMD_REQUEST;
        i_key       = '0;
        i_now       = '0;
        i_load_ok   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        idle_pct    = 14;
        phase_limit = '{5'd1, 5'd31, 5'd4, 5'd0, 5'd16, 5'd9};
        phase_idle  = '{14, 14, 50, 50, 0, 0};
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i]    = 1'b0;
            shadow_key[i]      = '0;
            shadow_last_use[i] = '0;
            shadow_users[i]    = '0;
        end
        shadow_limit = lcp_pkg::LIMIT_RESET;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);

        // Hold reset, release it on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            if (row.kind == ROW_CFG) begin
                write_limit(row.limit);
            end else begin
                typed_res.status      = row.status;
                typed_res.slot        = row.slot;
                typed_res.evicted_key = row.evicted_key;
                send_item(row.cmd, row.key, row.now, row.load_ok, row.typed, typed_res);
            end
        end

        // Saturate the user count of the one cached entry, then walk it back down
        now_stamp = 32'd100;
        repeat (258) begin
            now_stamp = now_stamp + 1;
            send_item(lcp_pkg::CMD_REQUEST, 32'd11, now_stamp, 1'b1, 1'b0, '0);
        end
        repeat (254) send_item(lcp_pkg::CMD_RELEASE, 32'd11, now_stamp, 1'b0, 1'b0, '0);
        send_item(lcp_pkg::CMD_REQUEST, 32'h5A5A_A5A5, now_stamp, 1'b1, 1'b0, '0);
        repeat (2) send_item(lcp_pkg::CMD_RELEASE, 32'd11, now_stamp, 1'b1, 1'b0, '0);

        // Random traffic, one limit setting per phase
        for (int p = 0; p < PHASES; p++) begin
            write_limit((p == PHASES - 1) ? lcp_pkg::LIMIT_BITS'($urandom_range(0, 31))
                                          : phase_limit[p]);
            idle_pct = phase_idle[p];
            now_stamp = TIME_W'($urandom);
            run_random_phase(PHASE_ITEMS);
        end

        // Drain and let the last transaction finish
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (2 * (ENTRIES + 3)) @(negedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
